// ===== rtl/wch_pkg.sv =====
// ----------------------------------------------------------------------------
// wch_pkg
// shared types and constants for the word count hash table
// ----------------------------------------------------------------------------
package wch_pkg;

   // table geometry, fixed by the response port widths
   localparam int SLOTS   = 128;
   localparam int MAX_KEY = 16;

   typedef enum logic [1:0] {
      CMD_FEED  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_LONG  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   localparam logic [7:0]  CHAR_SPACE = 8'd32;
   localparam logic [7:0]  CHAR_NL    = 8'd10;
   localparam logic [31:0] HASH_MUL   = 32'd13;
   localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

   // controller to datapath
   typedef struct packed {
      logic take_req;     // capture request fields
      logic feed;         // append byte and update hash
      logic probe_start;  // load probe slot from hash
      logic meta_rd;      // read slot metadata at probe slot
      logic cmp_rd;       // read one key byte at probe slot
      logic cmp_next;     // advance compare byte index
      logic probe_next;   // advance probe slot
      logic do_insert;    // start writing token into slot
      logic ins_byte;     // write one key byte
      logic do_bump;      // increment count at probe slot
      logic rd_slot;      // read metadata at read slot
      logic res_hit;      // load result from match
      logic res_ins;      // load result from insert
      logic res_read;     // load result from read
      logic res_full;     // load table full result
      logic res_long;     // load overlong result
      logic clr_token;    // clear token state
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    is_delim;
      logic    tok_empty;
      logic    tok_long;
      logic    slot_valid;  // valid bit at probe slot
      logic    len_eq;      // stored length equals token length
      logic    byte_eq;     // fetched key byte equals token byte
      logic    cmp_last;    // compare index at last token byte
      logic    probes_done; // all slots probed
      logic    ins_last;    // last key byte written
   } sts_type;

endpackage

// ===== rtl/wch_ctrl.sv =====
// ----------------------------------------------------------------------------
// wch_ctrl
// sequencer for feed, read and token-end probing
// ----------------------------------------------------------------------------
module wch_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  wch_pkg::sts_type sts,
   output wch_pkg::ctl_type ctl
);
   import wch_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_PSTART = 10'b0000000100,
      S_META   = 10'b0000001000,
      S_CHECK  = 10'b0000010000,
      S_CMPRD  = 10'b0000100000,
      S_CMP    = 10'b0001000000,
      S_INS    = 10'b0010000000,
      S_READ   = 10'b0100000000,
      S_BUMP   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               ctl.take_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.cmd)
               CMD_FEED: begin
                  if (!sts.is_delim) begin
                     ctl.feed = 1'b1;
                     state_in = S_IDLE;
                  end else if (sts.tok_long) begin
                     ctl.res_long  = 1'b1;
                     ctl.clr_token = 1'b1;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else if (sts.tok_empty) begin
                     state_in = S_IDLE;
                  end else begin
                     ctl.probe_start = 1'b1;
                     state_in        = S_PSTART;
                  end
               end
               CMD_FLUSH: begin
                  if (sts.tok_long) begin
                     ctl.res_long  = 1'b1;
                     ctl.clr_token = 1'b1;
                     rsp_valid_in  = 1'b1;
                     state_in      = S_IDLE;
                  end else if (sts.tok_empty) begin
                     state_in = S_IDLE;
                  end else begin
                     ctl.probe_start = 1'b1;
                     state_in        = S_PSTART;
                  end
               end
               CMD_READ: begin
                  ctl.rd_slot = 1'b1;
                  state_in    = S_READ;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PSTART: begin
            ctl.meta_rd = 1'b1;
            state_in    = S_META;
         end
         S_META: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.slot_valid) begin
               ctl.do_insert = 1'b1;
               state_in      = S_INS;
            end else if (sts.len_eq) begin
               ctl.cmp_rd = 1'b1;
               state_in   = S_CMPRD;
            end else if (sts.probes_done) begin
               ctl.res_full  = 1'b1;
               ctl.clr_token = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               ctl.probe_next = 1'b1;
               state_in       = S_PSTART;
            end
         end
         S_CMPRD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!sts.byte_eq) begin
               if (sts.probes_done) begin
                  ctl.res_full  = 1'b1;
                  ctl.clr_token = 1'b1;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  ctl.probe_next = 1'b1;
                  state_in       = S_PSTART;
               end
            end else if (sts.cmp_last) begin
               ctl.do_bump = 1'b1;
               state_in    = S_BUMP;
            end else begin
               ctl.cmp_next = 1'b1;
               ctl.cmp_rd   = 1'b1;
               state_in     = S_CMPRD;
            end
         end
         S_BUMP: begin
            ctl.res_hit   = 1'b1;
            ctl.clr_token = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_INS: begin
            ctl.ins_byte = 1'b1;
            if (sts.ins_last) begin
               ctl.res_ins   = 1'b1;
               ctl.clr_token = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            ctl.res_read = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.take_req |-> !rsp_valid_ff)
      else $error("request taken while result pending");
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != S_IDLE))
      else $error("result raised from idle");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request port open while busy");

endmodule

// ===== rtl/wch_datapath.sv =====
// ----------------------------------------------------------------------------
// wch_datapath
// token buffer, hash, slot memories and result register
// ----------------------------------------------------------------------------
module wch_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_text_byte,
   input  logic [6:0]       req_read_slot,
   input  wch_pkg::ctl_type ctl,
   output wch_pkg::sts_type sts,
   output logic [6:0]       rsp_slot_index,
   output logic [31:0]      rsp_word_count,
   output logic             rsp_slot_used,
   output logic             rsp_new_key,
   output logic [4:0]       rsp_key_length,
   output logic [1:0]       rsp_status
);
   import wch_pkg::*;

   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int KW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int LW  = $clog2(MAX_KEY + 1);
   localparam int PW  = $clog2(SLOTS + 1);
   localparam int BW  = SW + KW;

   // request capture
   cmd_type     cmd_ff;
   logic [7:0]  byte_ff;
   logic [6:0]  rslot_ff;

   // token state
   logic [7:0]    tok_buf_ff [MAX_KEY];
   logic [LW-1:0] tok_len_ff, tok_len_in;
   logic [31:0]   hash_ff, hash_in;
   logic          long_ff, long_in;

   // probe state
   logic [SW-1:0] slot_ff;
   logic [PW-1:0] probes_ff;
   logic [KW-1:0] idx_ff;
   logic [KW-1:0] ins_ff;

   // slot memories
   logic [7:0]    key_mem   [SLOTS*MAX_KEY];
   logic [LW-1:0] len_mem   [SLOTS];
   logic [31:0]   cnt_mem   [SLOTS];
   logic          valid_ff  [SLOTS];

   logic [LW-1:0] len_rd_ff;
   logic [31:0]   cnt_rd_ff;
   logic          vld_rd_ff;
   logic [7:0]    key_rd_ff;
   logic [31:0]   cnt_bump;

   logic [SW-1:0] rd_addr;
   logic [SW-1:0] meta_addr;
   logic [SW-1:0] hash_slot;

   logic [6:0]  res_slot_ff;
   logic [31:0] res_cnt_ff;
   logic        res_used_ff;
   logic        res_new_ff;
   logic [4:0]  res_len_ff;
   status_type  res_st_ff;

   function automatic logic [31:0] req_rd_mod(input logic [6:0] s);
      req_rd_mod = 32'(s) % 32'(SLOTS);
   endfunction

   assign rd_addr   = SW'(req_rd_mod(rslot_ff));
   assign hash_slot = SW'(hash_ff % 32'(SLOTS));
   assign meta_addr = ctl.rd_slot ? rd_addr : slot_ff;

   always_ff @(posedge clock) begin
      if (ctl.take_req) begin
         cmd_ff   <= cmd_type'(req_command);
         byte_ff  <= req_text_byte;
         rslot_ff <= req_read_slot;
      end
   end

   // token accumulation
   always_comb begin
      tok_len_in = tok_len_ff;
      hash_in    = hash_ff;
      long_in    = long_ff;
      if (ctl.clr_token) begin
         tok_len_in = '0;
         hash_in    = '0;
         long_in    = 1'b0;
      end else if (ctl.feed) begin
         hash_in = hash_ff * HASH_MUL + 32'(byte_ff);
         if (tok_len_ff < LW'(MAX_KEY)) begin
            tok_len_in = tok_len_ff + 1'b1;
         end else begin
            long_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_len_ff <= '0;
         hash_ff    <= '0;
         long_ff    <= 1'b0;
      end else begin
         tok_len_ff <= tok_len_in;
         hash_ff    <= hash_in;
         long_ff    <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.feed && tok_len_ff < LW'(MAX_KEY)) begin
         tok_buf_ff[tok_len_ff[KW-1:0]] <= byte_ff;
      end
   end

   // probe sequencing
   always_ff @(posedge clock) begin
      if (ctl.probe_start) begin
         slot_ff   <= hash_slot;
         probes_ff <= PW'(1);
      end else if (ctl.probe_next) begin
         slot_ff   <= (32'(slot_ff) == SLOTS - 1) ? '0 : slot_ff + 1'b1;
         probes_ff <= probes_ff + 1'b1;
      end
      if (ctl.probe_start || ctl.probe_next) begin
         idx_ff <= '0;
      end else if (ctl.cmp_next) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (ctl.do_insert) begin
         ins_ff <= '0;
      end else if (ctl.ins_byte) begin
         ins_ff <= ins_ff + 1'b1;
      end
   end

   // metadata memories
   assign cnt_bump = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (ctl.meta_rd || ctl.rd_slot) begin
         len_rd_ff <= len_mem[meta_addr];
         cnt_rd_ff <= cnt_mem[meta_addr];
      end
      if (ctl.do_insert) begin
         len_mem[slot_ff] <= tok_len_ff;
         cnt_mem[slot_ff] <= 32'd1;
      end else if (ctl.do_bump) begin
         cnt_mem[slot_ff] <= cnt_bump;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) valid_ff[i] <= 1'b0;
      end else if (ctl.do_insert) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.meta_rd || ctl.rd_slot) begin
         vld_rd_ff <= valid_ff[meta_addr];
      end
   end

   // key byte memory, one port each way
   always_ff @(posedge clock) begin
      if (ctl.cmp_rd) begin
         key_rd_ff <= key_mem[{slot_ff, ctl.cmp_next ? idx_ff + 1'b1 : idx_ff}];
      end
      if (ctl.ins_byte) begin
         key_mem[BW'({slot_ff, ins_ff})] <= tok_buf_ff[ins_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctl.res_hit) begin
         res_slot_ff <= 7'(slot_ff);
         res_cnt_ff  <= cnt_bump;
         res_used_ff <= 1'b1;
         res_new_ff  <= 1'b0;
         res_len_ff  <= 5'(len_rd_ff);
         res_st_ff   <= ST_OK;
      end else if (ctl.res_ins) begin
         res_slot_ff <= 7'(slot_ff);
         res_cnt_ff  <= 32'd1;
         res_used_ff <= 1'b1;
         res_new_ff  <= 1'b1;
         res_len_ff  <= 5'(tok_len_ff);
         res_st_ff   <= ST_OK;
      end else if (ctl.res_read) begin
         res_slot_ff <= 7'(rd_addr);
         res_cnt_ff  <= vld_rd_ff ? cnt_rd_ff : 32'd0;
         res_used_ff <= vld_rd_ff;
         res_new_ff  <= 1'b0;
         res_len_ff  <= vld_rd_ff ? 5'(len_rd_ff) : 5'd0;
         res_st_ff   <= ST_OK;
      end else if (ctl.res_full || ctl.res_long) begin
         res_slot_ff <= '0;
         res_cnt_ff  <= '0;
         res_used_ff <= 1'b0;
         res_new_ff  <= 1'b0;
         res_len_ff  <= '0;
         res_st_ff   <= ctl.res_full ? ST_FULL : ST_LONG;
      end
   end

   assign rsp_slot_index = res_slot_ff;
   assign rsp_word_count = res_cnt_ff;
   assign rsp_slot_used  = res_used_ff;
   assign rsp_new_key    = res_new_ff;
   assign rsp_key_length = res_len_ff;
   assign rsp_status     = res_st_ff;

   always_comb begin
      sts             = '0;
      sts.cmd         = cmd_ff;
      sts.is_delim    = (byte_ff == CHAR_SPACE) || (byte_ff == CHAR_NL);
      sts.tok_empty   = (tok_len_ff == '0);
      sts.tok_long    = long_ff;
      sts.slot_valid  = vld_rd_ff;
      sts.len_eq      = (len_rd_ff == tok_len_ff);
      sts.byte_eq     = (key_rd_ff == tok_buf_ff[idx_ff]);
      sts.cmp_last    = (LW'(idx_ff) + 1'b1 == tok_len_ff);
      sts.probes_done = (probes_ff == PW'(SLOTS));
      sts.ins_last    = (LW'(ins_ff) + 1'b1 == tok_len_ff);
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      tok_len_ff <= LW'(MAX_KEY))
      else $error("token length beyond max");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clr_token |=> (tok_len_ff == '0) && !long_ff && (hash_ff == '0))
      else $error("token state not cleared");
   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.do_insert |-> (tok_len_ff != '0) && !long_ff)
      else $error("insert of empty or long token");

endmodule

// ===== rtl/word_count_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// word_count_hash_table_top
// word frequency counter over an open-addressed, linearly probed table
// ----------------------------------------------------------------------------
// One request beat is taken at a time. A text byte that is not a delimiter
// gives no response. A token end (space, newline or flush) probes the table
// starting at hash mod SLOTS; each probed slot passes through S_PSTART,
// S_META and S_CHECK for its metadata read and check, plus S_CMPRD and S_CMP
// per key byte compared when the stored length matches, a hit goes through
// S_BUMP for the count update, and an insert writes the key one byte per
// cycle through the single write port of the key memory. Requests stall
// while a response beat waits. Used flags clear on reset; key, length and
// count storage is never cleared.
module word_count_hash_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_text_byte,
   input  logic [6:0]  req_read_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_slot_index,
   output logic [31:0] rsp_word_count,
   output logic        rsp_slot_used,
   output logic        rsp_new_key,
   output logic [4:0]  rsp_key_length,
   output logic [1:0]  rsp_status
);
   import wch_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // sequencer
   wch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // storage and arithmetic
   wch_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_text_byte  (req_text_byte),
      .req_read_slot  (req_read_slot),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_slot_index (rsp_slot_index),
      .rsp_word_count (rsp_word_count),
      .rsp_slot_used  (rsp_slot_used),
      .rsp_new_key    (rsp_new_key),
      .rsp_key_length (rsp_key_length),
      .rsp_status     (rsp_status)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_count))
      else $error("stalled response changed");
   a_new_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_key |-> rsp_slot_used && (rsp_word_count == 32'd1))
      else $error("new key without fresh count");
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> !rsp_slot_used)
      else $error("dropped token reports a slot");

endmodule
